// ===== rtl/core/stbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants of the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 32;
  localparam int POS_W               = 6;
  localparam int CNT_W               = 6;
  localparam int DATA_W              = 32;
  localparam int RANGE_W             = POS_W + 1;
  localparam int APB_ADDR_W          = 3;
  localparam int APB_DATA_W          = 32;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef struct packed {
    logic load;
    logic start;
    logic probe;
    logic check;
    logic post;
  } stbs_ctrl_t;

  typedef struct packed {
    logic range_empty;
    logic hit;
    logic out_free;
  } stbs_stat_t;

endpackage

// ===== rtl/core/stbs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface stbs_in_if
  import stbs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [POS_W-1:0]         entry_position;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, output cmd, output entry_position, output data_value,
                  input ready);
  modport sink   (input valid, input cmd, input entry_position, input data_value,
                  output ready);
endinterface

interface stbs_out_if
  import stbs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] match_position;

  modport source (output valid, output found, output match_position, input ready);
  modport sink   (input valid, input found, input match_position, output ready);
endinterface

// ===== rtl/core/stbs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller: sequences load, probe, check and result posting.
// ----------------------------------------------------------------------------
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  input  stbs_stat_t stat,
  output stbs_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PROBE = 4'b0010,
    S_CHECK = 4'b0100,
    S_POST  = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_SEARCH) begin
            ctrl.start = 1'b1;
            state_next = S_PROBE;
          end else begin
            ctrl.load = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (stat.range_empty) begin
          state_next = S_POST;
        end else begin
          ctrl.probe = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        ctrl.check = 1'b1;
        state_next = stat.hit ? S_POST : S_PROBE;
      end
      S_POST: begin
        if (stat.out_free) begin
          ctrl.post  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/stbs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_datapath
// Table memory, search range registers, key compare and result register.
// ----------------------------------------------------------------------------
module stbs_datapath
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  stbs_ctrl_t               ctrl,
  output stbs_stat_t               stat,
  input  logic [CNT_W-1:0]         entry_count,
  input  logic [POS_W-1:0]         entry_position,
  input  logic signed [DATA_W-1:0] data_value,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [POS_W-1:0]         out_match_position
);

  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int POS_MAX = (2 ** POS_W) - 1;
  localparam int CAP_INT = (TABLE_DEPTH > POS_MAX) ? POS_MAX : TABLE_DEPTH;
  localparam logic [POS_W-1:0] DEPTH_CAP = POS_W'(CAP_INT);

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];

  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] rd_data;
  logic [RANGE_W-1:0]       low;
  logic [RANGE_W-1:0]       high;
  logic [POS_W-1:0]         mid;
  logic                     res_found;
  logic [POS_W-1:0]         res_pos;

  logic [POS_W-1:0]         count_eff;
  logic                     wr_ok;
  logic [POS_W-1:0]         wr_pos_m1;
  logic [POS_W+ADDR_W-1:0]  wr_wide;
  logic [ADDR_W-1:0]        wr_addr;
  logic [RANGE_W:0]         range_sum;
  logic [RANGE_W-1:0]       mid_wide;
  logic [POS_W-1:0]         mid_calc;
  logic [POS_W-1:0]         rd_pos_m1;
  logic [POS_W+ADDR_W-1:0]  rd_wide;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     hit;

  assign count_eff = (entry_count > DEPTH_CAP) ? DEPTH_CAP : entry_count;

  assign wr_ok     = (entry_position != '0) && (entry_position <= DEPTH_CAP);
  assign wr_pos_m1 = entry_position - POS_W'(1);
  assign wr_wide   = {{ADDR_W{1'b0}}, wr_pos_m1};
  assign wr_addr   = wr_wide[ADDR_W-1:0];

  // midpoint of the inclusive range [low, high], rounded down
  assign range_sum = {1'b0, low} + {1'b0, high};
  assign mid_wide  = range_sum[RANGE_W:1];
  assign mid_calc  = mid_wide[POS_W-1:0];
  assign rd_pos_m1 = mid_calc - POS_W'(1);
  assign rd_wide   = {{ADDR_W{1'b0}}, rd_pos_m1};
  assign rd_addr   = rd_wide[ADDR_W-1:0];

  assign hit = (key == rd_data);

  assign stat.range_empty = (low > high);
  assign stat.hit         = hit;
  assign stat.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (ctrl.load && wr_ok) begin
      mem[wr_addr] <= data_value;
    end
    if (ctrl.probe) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      key       <= data_value;
      low       <= RANGE_W'(1);
      high      <= {1'b0, count_eff};
      res_found <= 1'b0;
      res_pos   <= '0;
    end
    if (ctrl.probe) begin
      mid <= mid_calc;
    end
    if (ctrl.check) begin
      if (hit) begin
        res_found <= 1'b1;
        res_pos   <= mid;
      end else if (key < rd_data) begin
        high <= {1'b0, mid} - RANGE_W'(1);
      end else begin
        low <= {1'b0, mid} + RANGE_W'(1);
      end
    end
    if (ctrl.post) begin
      out_found          <= res_found;
      out_match_position <= res_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.post) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a table of signed entries loaded one at a time.
// Load: accepted with no response; next request the cycle after.
// Search: each probe is a memory read, then a compare; the result is posted on a
//   hit or once the range is empty, and waits while the response is stalled.
// One search at a time: the next request is taken the cycle after the response
//   is posted.
// Reset clears entry_count and control state; table contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  stbs_in_if.sink               req,
  stbs_out_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CNT_W-1:0] entry_count;
  logic             reg_sel;
  logic             cfg_wr;
  stbs_ctrl_t       ctrl;
  stbs_stat_t       stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_ENTRY_COUNT);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? {{(APB_DATA_W-CNT_W){1'b0}}, entry_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr) begin
      entry_count <= pwdata[CNT_W-1:0];
    end
  end

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (req.cmd),
    .in_ready (req.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .ctrl               (ctrl),
    .stat               (stat),
    .entry_count        (entry_count),
    .entry_position     (req.entry_position),
    .data_value         (req.data_value),
    .out_ready          (rsp.ready),
    .out_valid          (rsp.valid),
    .out_found          (rsp.found),
    .out_match_position (rsp.match_position)
  );

endmodule

// ===== rtl/core/stbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks of the search block, bound to the top level.
// ----------------------------------------------------------------------------
module stbs_checker
  import stbs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             req_cmd,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic             rsp_found,
  input logic [POS_W-1:0] rsp_match_position
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
      && $stable(rsp_match_position))
    else $error("response dropped or changed while stalled");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_match_position == '0)
    else $error("miss with nonzero position");

  a_hit_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> rsp_match_position != '0)
    else $error("hit at position zero");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd == CMD_SEARCH |=> !req_ready)
    else $error("request taken during search");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .req_cmd            (req.cmd),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_found          (rsp.found),
  .rsp_match_position (rsp.match_position)
);
